/* rtl/astar_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// astar_pkg
// Shared sizes, field offsets, codes and types of the A* path search core.
// ----------------------------------------------------------------------------
package astar_pkg;

    localparam int MAX_NODES   = 64;
    localparam int COORD_BITS  = 24;
    localparam int NODE_BITS   = 6;
    localparam int IDX_BITS    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int COST_BITS   = 32;
    localparam int F_BITS      = COST_BITS + 1;
    localparam int SQ_BITS     = 2 * COORD_BITS;
    localparam int ROOT_BITS   = COORD_BITS + 1;
    localparam int SUM_BITS    = 2 * ROOT_BITS;
    localparam int REM_BITS    = ROOT_BITS + 2;
    localparam int CNT_BITS    = $clog2(ROOT_BITS);
    localparam int OP_BITS     = 2;
    localparam int STATUS_BITS = 2;

    localparam int IN_FIELD_BITS  = 4 * NODE_BITS + 3 * COORD_BITS;
    localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((NODE_BITS + 7) / 8) * 8;

    localparam int OFS_NODE = 0;
    localparam int OFS_NBR  = NODE_BITS;
    localparam int OFS_X    = 2 * NODE_BITS;
    localparam int OFS_Y    = OFS_X + COORD_BITS;
    localparam int OFS_Z    = OFS_Y + COORD_BITS;
    localparam int OFS_FROM = OFS_Z + COORD_BITS;
    localparam int OFS_TO   = OFS_FROM + NODE_BITS;

    typedef logic [NODE_BITS-1:0] node_t;
    typedef logic [IDX_BITS-1:0]  idx_t;
    typedef logic [MAX_NODES-1:0] mask_t;
    typedef logic [COST_BITS-1:0] cost_t;

    typedef enum logic [OP_BITS-1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_EDGE  = 2'd2,
        OP_FIND  = 2'd3
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_PATH    = 2'd0,
        ST_SAME    = 2'd1,
        ST_UNREACH = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        DIST_IDLE,
        DIST_SQ,
        DIST_ROOT
    } dist_state_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GOAL,
        S_SEL_INIT,
        S_SEL_SCAN,
        S_SEL_DIST,
        S_SEL_WAIT,
        S_SEL_DONE,
        S_EXP_LOAD,
        S_EXP_SCAN,
        S_EXP_DIST,
        S_EXP_WAIT,
        S_WALK_PUSH,
        S_WALK_WAIT,
        S_POP_RD,
        S_POP_OUT,
        S_SINGLE
    } search_state_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } pos_t;

    typedef struct packed {
        cost_t cost;
        idx_t  prev;
    } cost_entry_t;

    typedef struct packed {
        logic  clear;
        logic  load;
        logic  add_edge;
        node_t node;
        node_t nbr;
        pos_t  pos;
    } graph_wr_t;

    typedef struct packed {
        logic pos_en;
        idx_t pos_addr;
        logic adj_en;
        idx_t adj_addr;
    } graph_rd_t;

    typedef struct packed {
        logic  valid;
        node_t from_node;
        node_t to_node;
    } query_t;

    typedef struct packed {
        logic start;
        pos_t a;
        pos_t b;
    } dist_req_t;

    function automatic logic node_ok(input node_t n);
        return ({1'b0, n} < (NODE_BITS + 1)'(MAX_NODES));
    endfunction

    function automatic mask_t idx_bit(input idx_t i);
        return mask_t'(1) << i;
    endfunction

endpackage

/* rtl/astar_dist.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// astar_dist
// Floor Euclidean distance: three squares on one multiplier, then a
// restoring square root that settles one result bit per cycle.
// ----------------------------------------------------------------------------
module astar_dist (
    input  logic                              clk,
    input  logic                              rst_n,
    input  astar_pkg::dist_req_t              req,
    output logic                              done,
    output logic [astar_pkg::ROOT_BITS-1:0]   distance
);

    astar_pkg::dist_state_t state_reg, state_next;
    logic [astar_pkg::CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [astar_pkg::COORD_BITS-1:0] d_reg [3];
    logic [astar_pkg::COORD_BITS-1:0] d_next [3];
    logic [astar_pkg::SQ_BITS-1:0]    prod_reg, prod_next;
    logic [astar_pkg::SUM_BITS-1:0]   acc_reg, acc_next;
    logic [astar_pkg::REM_BITS-1:0]   rem_reg, rem_next;
    logic [astar_pkg::ROOT_BITS-1:0]  root_reg, root_next;
    logic                             done_reg, done_next;
    logic [astar_pkg::REM_BITS+1:0]   rem_sh;
    logic [astar_pkg::REM_BITS+1:0]   trial;

    function automatic logic [astar_pkg::COORD_BITS-1:0] abs_diff(
        input logic signed [astar_pkg::COORD_BITS-1:0] a,
        input logic signed [astar_pkg::COORD_BITS-1:0] b
    );
        logic signed [astar_pkg::COORD_BITS:0] d;
        d = {a[astar_pkg::COORD_BITS-1], a} - {b[astar_pkg::COORD_BITS-1], b};
        return d[astar_pkg::COORD_BITS] ? astar_pkg::COORD_BITS'(-d)
                                         : d[astar_pkg::COORD_BITS-1:0];
    endfunction

    assign rem_sh = {rem_reg, acc_reg[astar_pkg::SUM_BITS-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= astar_pkg::DIST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg    <= d_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        d_next     = d_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            astar_pkg::DIST_IDLE:
            begin
                if (req.start)
                begin
                    d_next[0]  = abs_diff(req.a.x, req.b.x);
                    d_next[1]  = abs_diff(req.a.y, req.b.y);
                    d_next[2]  = abs_diff(req.a.z, req.b.z);
                    prod_next  = '0;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = astar_pkg::DIST_SQ;
                end
            end
            astar_pkg::DIST_SQ:
            begin
                // product is registered, summed in the next cycle
                acc_next  = acc_reg + astar_pkg::SUM_BITS'(prod_reg);
                prod_next = d_reg[0] * d_reg[0];
                d_next[0] = d_reg[1];
                d_next[1] = d_reg[2];
                d_next[2] = '0;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == astar_pkg::CNT_BITS'(3))
                begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    root_next  = '0;
                    state_next = astar_pkg::DIST_ROOT;
                end
            end
            astar_pkg::DIST_ROOT:
            begin
                acc_next = acc_reg << 2;
                if (rem_sh >= trial)
                begin
                    rem_next  = astar_pkg::REM_BITS'(rem_sh - trial);
                    root_next = {root_reg[astar_pkg::ROOT_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh[astar_pkg::REM_BITS-1:0];
                    root_next = {root_reg[astar_pkg::ROOT_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == astar_pkg::CNT_BITS'(astar_pkg::ROOT_BITS - 1))
                begin
                    done_next  = 1'b1;
                    state_next = astar_pkg::DIST_IDLE;
                end
            end
            default:
            begin
                state_next = astar_pkg::DIST_IDLE;
            end
        endcase
    end

    assign done     = done_reg;
    assign distance = root_reg;

    a_done_after_root: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) == astar_pkg::DIST_ROOT)
        else $error("distance done without root pass");

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != astar_pkg::DIST_IDLE) |-> !req.start)
        else $error("distance started while busy");

    a_root_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == astar_pkg::DIST_ROOT)
        |-> ({1'b0, rem_reg} <= ({2'b00, root_reg, 1'b0})))
        else $error("square root remainder out of range");

endmodule

/* rtl/astar_graph.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// astar_graph
// Graph store: node position memory, adjacency row memory with row valid
// bits, and the node present mask.
// ----------------------------------------------------------------------------
module astar_graph (
    input  logic                  clk,
    input  logic                  rst_n,
    input  astar_pkg::graph_wr_t  wr,
    input  astar_pkg::graph_rd_t  rd,
    output astar_pkg::pos_t       pos_rd,
    output astar_pkg::mask_t      adj_rd,
    output astar_pkg::mask_t      present
);

    astar_pkg::pos_t  pos_mem [astar_pkg::MAX_NODES];
    astar_pkg::mask_t adj_mem [astar_pkg::MAX_NODES];

    astar_pkg::mask_t present_reg, present_next;
    astar_pkg::mask_t row_valid_reg, row_valid_next;
    astar_pkg::pos_t  pos_rd_reg;
    astar_pkg::mask_t adj_rd_reg;
    logic             adj_ok_reg;

    logic             load_ok;
    logic             edge_ok;
    astar_pkg::idx_t  node_idx;
    astar_pkg::idx_t  nbr_idx;

    assign node_idx = wr.node[astar_pkg::IDX_BITS-1:0];
    assign nbr_idx  = wr.nbr[astar_pkg::IDX_BITS-1:0];
    assign load_ok  = wr.load && astar_pkg::node_ok(wr.node);
    assign edge_ok  = wr.add_edge && astar_pkg::node_ok(wr.node)
                      && astar_pkg::node_ok(wr.nbr);

    always_comb
    begin
        present_next   = present_reg;
        row_valid_next = row_valid_reg;
        if (wr.clear)
        begin
            present_next   = '0;
            row_valid_next = '0;
        end
        if (load_ok)
        begin
            present_next = present_reg | astar_pkg::idx_bit(node_idx);
        end
        if (edge_ok)
        begin
            row_valid_next = row_valid_reg | astar_pkg::idx_bit(node_idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg   <= '0;
            row_valid_reg <= '0;
        end
        else
        begin
            present_reg   <= present_next;
            row_valid_reg <= row_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            pos_mem[node_idx] <= wr.pos;
        end
        if (rd.pos_en)
        begin
            pos_rd_reg <= pos_mem[rd.pos_addr];
        end
    end

    // a row that is not valid was cleared: first edge rewrites it whole
    always_ff @(posedge clk)
    begin
        if (edge_ok)
        begin
            if (row_valid_reg[node_idx])
            begin
                adj_mem[node_idx][nbr_idx] <= 1'b1;
            end
            else
            begin
                adj_mem[node_idx] <= astar_pkg::idx_bit(nbr_idx);
            end
        end
        if (rd.adj_en)
        begin
            adj_rd_reg <= adj_mem[rd.adj_addr];
            adj_ok_reg <= row_valid_reg[rd.adj_addr];
        end
    end

    assign pos_rd  = pos_rd_reg;
    assign adj_rd  = adj_rd_reg & {astar_pkg::MAX_NODES{adj_ok_reg}} & present_reg;
    assign present = present_reg;

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.clear && !wr.load && !wr.add_edge) |=> (present_reg == '0))
        else $error("clear left nodes present");

    a_load_marks: assert property (@(posedge clk) disable iff (!rst_n)
        load_ok |=> present_reg[$past(node_idx)])
        else $error("loaded node not present");

    a_edge_row_valid: assert property (@(posedge clk) disable iff (!rst_n)
        edge_ok |=> row_valid_reg[$past(node_idx)])
        else $error("edge row not valid after write");

endmodule

/* rtl/astar_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// astar_search
// A* sequencer: open scan for lowest f, neighbor relaxation through the
// cost memory, path walk onto a stack and output register.
// ----------------------------------------------------------------------------
module astar_search (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  astar_pkg::query_t                      query,
    output logic                                   idle,
    output astar_pkg::graph_rd_t                   rd,
    input  astar_pkg::pos_t                        pos_rd,
    input  astar_pkg::mask_t                       adj_rd,
    input  astar_pkg::mask_t                       present,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output astar_pkg::node_t                       out_node,
    output logic                                   out_last,
    output astar_pkg::status_t                     out_status
);

    localparam int N_BITS = astar_pkg::IDX_BITS + 1;

    astar_pkg::search_state_t state_reg, state_next;

    astar_pkg::idx_t     from_reg, from_next;
    astar_pkg::idx_t     to_reg, to_next;
    astar_pkg::idx_t     idx_reg, idx_next;
    astar_pkg::idx_t     best_idx_reg, best_idx_next;
    logic [astar_pkg::F_BITS-1:0] best_reg, best_next;
    logic                have_best_reg, have_best_next;
    astar_pkg::pos_t     goal_pos_reg, goal_pos_next;
    astar_pkg::pos_t     u_pos_reg, u_pos_next;
    astar_pkg::cost_t    u_cost_reg, u_cost_next;
    astar_pkg::cost_t    cand_cost_reg, cand_cost_next;
    astar_pkg::mask_t    nb_reg, nb_next;
    astar_pkg::mask_t    open_reg, open_next;
    astar_pkg::mask_t    closed_reg, closed_next;
    logic [N_BITS-1:0]   n_reg, n_next;
    astar_pkg::idx_t     v_reg, v_next;
    astar_pkg::status_t  status_reg, status_next;

    logic                out_valid_reg, out_valid_next;
    astar_pkg::node_t    out_node_reg, out_node_next;
    logic                out_last_reg, out_last_next;
    astar_pkg::status_t  out_status_reg, out_status_next;

    astar_pkg::cost_entry_t cost_mem [astar_pkg::MAX_NODES];
    astar_pkg::cost_entry_t cost_rd_reg;
    astar_pkg::cost_entry_t cost_wdata;
    logic                   cost_we;
    astar_pkg::idx_t        cost_waddr;
    logic                   cost_re;
    astar_pkg::idx_t        cost_raddr;

    astar_pkg::idx_t        stack_mem [astar_pkg::MAX_NODES];
    astar_pkg::idx_t        stack_rd_reg;
    logic                   stack_we;
    logic                   stack_re;
    astar_pkg::idx_t        stack_raddr;

    astar_pkg::dist_req_t   dist_req;
    logic                   dist_done;
    logic [astar_pkg::ROOT_BITS-1:0] dist_val;

    logic                   slot_free;
    logic                   idx_last;
    logic [astar_pkg::F_BITS-1:0] f_sum;
    logic [astar_pkg::F_BITS-1:0] g_sum;
    astar_pkg::cost_t       g_sat;
    astar_pkg::idx_t        q_from;
    astar_pkg::idx_t        q_to;

    astar_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (dist_req),
        .done     (dist_done),
        .distance (dist_val)
    );

    assign slot_free = !out_valid_reg || out_ready;
    assign idx_last  = (idx_reg == astar_pkg::idx_t'(astar_pkg::MAX_NODES - 1));
    assign f_sum     = {1'b0, cand_cost_reg} + astar_pkg::F_BITS'(dist_val);
    assign g_sum     = {1'b0, u_cost_reg} + astar_pkg::F_BITS'(dist_val);
    assign g_sat     = g_sum[astar_pkg::COST_BITS] ? '1 : g_sum[astar_pkg::COST_BITS-1:0];
    assign q_from    = query.from_node[astar_pkg::IDX_BITS-1:0];
    assign q_to      = query.to_node[astar_pkg::IDX_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= astar_pkg::S_IDLE;
            open_reg      <= '0;
            closed_reg    <= '0;
            n_reg         <= '0;
            have_best_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            open_reg      <= open_next;
            closed_reg    <= closed_next;
            n_reg         <= n_next;
            have_best_reg <= have_best_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        from_reg       <= from_next;
        to_reg         <= to_next;
        idx_reg        <= idx_next;
        best_idx_reg   <= best_idx_next;
        best_reg       <= best_next;
        goal_pos_reg   <= goal_pos_next;
        u_pos_reg      <= u_pos_next;
        u_cost_reg     <= u_cost_next;
        cand_cost_reg  <= cand_cost_next;
        nb_reg         <= nb_next;
        v_reg          <= v_next;
        status_reg     <= status_next;
        out_node_reg   <= out_node_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (cost_we)
        begin
            cost_mem[cost_waddr] <= cost_wdata;
        end
        if (cost_re)
        begin
            cost_rd_reg <= cost_mem[cost_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[n_reg[astar_pkg::IDX_BITS-1:0]] <= v_reg;
        end
        if (stack_re)
        begin
            stack_rd_reg <= stack_mem[stack_raddr];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        from_next       = from_reg;
        to_next         = to_reg;
        idx_next        = idx_reg;
        best_idx_next   = best_idx_reg;
        best_next       = best_reg;
        have_best_next  = have_best_reg;
        goal_pos_next   = goal_pos_reg;
        u_pos_next      = u_pos_reg;
        u_cost_next     = u_cost_reg;
        cand_cost_next  = cand_cost_reg;
        nb_next         = nb_reg;
        open_next       = open_reg;
        closed_next     = closed_reg;
        n_next          = n_reg;
        v_next          = v_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_node_next   = out_node_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        rd              = '0;
        cost_we         = 1'b0;
        cost_waddr      = idx_reg;
        cost_wdata      = '0;
        cost_re         = 1'b0;
        cost_raddr      = idx_reg;
        stack_we        = 1'b0;
        stack_re        = 1'b0;
        stack_raddr     = astar_pkg::idx_t'(n_reg - 1'b1);
        dist_req.start  = 1'b0;
        dist_req.a      = pos_rd;
        dist_req.b      = goal_pos_reg;

        unique case (state_reg)
            astar_pkg::S_IDLE:
            begin
                if (query.valid)
                begin
                    from_next = q_from;
                    to_next   = q_to;
                    if (query.from_node == query.to_node)
                    begin
                        status_next = astar_pkg::ST_SAME;
                        state_next  = astar_pkg::S_SINGLE;
                    end
                    else if (!astar_pkg::node_ok(query.from_node)
                             || !astar_pkg::node_ok(query.to_node))
                    begin
                        status_next = astar_pkg::ST_UNREACH;
                        state_next  = astar_pkg::S_SINGLE;
                    end
                    else if (!present[q_from] || !present[q_to])
                    begin
                        status_next = astar_pkg::ST_UNREACH;
                        state_next  = astar_pkg::S_SINGLE;
                    end
                    else
                    begin
                        rd.pos_en       = 1'b1;
                        rd.pos_addr     = q_to;
                        cost_we         = 1'b1;
                        cost_waddr      = q_from;
                        cost_wdata.cost = '0;
                        cost_wdata.prev = q_from;
                        open_next       = astar_pkg::idx_bit(q_from);
                        closed_next     = '0;
                        state_next      = astar_pkg::S_GOAL;
                    end
                end
            end
            astar_pkg::S_GOAL:
            begin
                goal_pos_next = pos_rd;
                state_next    = astar_pkg::S_SEL_INIT;
            end
            astar_pkg::S_SEL_INIT:
            begin
                if (open_reg == '0)
                begin
                    status_next = astar_pkg::ST_UNREACH;
                    state_next  = astar_pkg::S_SINGLE;
                end
                else
                begin
                    idx_next       = '0;
                    have_best_next = 1'b0;
                    state_next     = astar_pkg::S_SEL_SCAN;
                end
            end
            astar_pkg::S_SEL_SCAN:
            begin
                if (open_reg[idx_reg])
                begin
                    rd.pos_en   = 1'b1;
                    rd.pos_addr = idx_reg;
                    cost_re     = 1'b1;
                    state_next  = astar_pkg::S_SEL_DIST;
                end
                else if (idx_last)
                begin
                    state_next = astar_pkg::S_SEL_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            astar_pkg::S_SEL_DIST:
            begin
                dist_req.start = 1'b1;
                cand_cost_next = cost_rd_reg.cost;
                state_next     = astar_pkg::S_SEL_WAIT;
            end
            astar_pkg::S_SEL_WAIT:
            begin
                if (dist_done)
                begin
                    // strict compare keeps the lower index on a tie
                    if (!have_best_reg || (f_sum < best_reg))
                    begin
                        best_next      = f_sum;
                        best_idx_next  = idx_reg;
                        have_best_next = 1'b1;
                    end
                    if (idx_last)
                    begin
                        state_next = astar_pkg::S_SEL_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = astar_pkg::S_SEL_SCAN;
                    end
                end
            end
            astar_pkg::S_SEL_DONE:
            begin
                open_next   = open_reg & ~astar_pkg::idx_bit(best_idx_reg);
                closed_next = closed_reg | astar_pkg::idx_bit(best_idx_reg);
                if (best_idx_reg == to_reg)
                begin
                    v_next     = to_reg;
                    n_next     = '0;
                    state_next = astar_pkg::S_WALK_PUSH;
                end
                else
                begin
                    rd.adj_en   = 1'b1;
                    rd.adj_addr = best_idx_reg;
                    rd.pos_en   = 1'b1;
                    rd.pos_addr = best_idx_reg;
                    cost_re     = 1'b1;
                    cost_raddr  = best_idx_reg;
                    state_next  = astar_pkg::S_EXP_LOAD;
                end
            end
            astar_pkg::S_EXP_LOAD:
            begin
                nb_next     = adj_rd;
                u_pos_next  = pos_rd;
                u_cost_next = cost_rd_reg.cost;
                idx_next    = '0;
                state_next  = astar_pkg::S_EXP_SCAN;
            end
            astar_pkg::S_EXP_SCAN:
            begin
                if (nb_reg[idx_reg])
                begin
                    rd.pos_en   = 1'b1;
                    rd.pos_addr = idx_reg;
                    cost_re     = 1'b1;
                    state_next  = astar_pkg::S_EXP_DIST;
                end
                else if (idx_last)
                begin
                    state_next = astar_pkg::S_SEL_INIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            astar_pkg::S_EXP_DIST:
            begin
                dist_req.start = 1'b1;
                dist_req.b     = u_pos_reg;
                cand_cost_next = cost_rd_reg.cost;
                state_next     = astar_pkg::S_EXP_WAIT;
            end
            astar_pkg::S_EXP_WAIT:
            begin
                if (dist_done)
                begin
                    // unseen node or better cost: (re)open it
                    if (!(open_reg[idx_reg] || closed_reg[idx_reg])
                        || (g_sat < cand_cost_reg))
                    begin
                        cost_we         = 1'b1;
                        cost_wdata.cost = g_sat;
                        cost_wdata.prev = best_idx_reg;
                        closed_next     = closed_reg & ~astar_pkg::idx_bit(idx_reg);
                        open_next       = open_reg | astar_pkg::idx_bit(idx_reg);
                    end
                    if (idx_last)
                    begin
                        state_next = astar_pkg::S_SEL_INIT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = astar_pkg::S_EXP_SCAN;
                    end
                end
            end
            astar_pkg::S_WALK_PUSH:
            begin
                if (n_reg == N_BITS'(astar_pkg::MAX_NODES))
                begin
                    status_next = astar_pkg::ST_UNREACH;
                    state_next  = astar_pkg::S_SINGLE;
                end
                else
                begin
                    stack_we = 1'b1;
                    n_next   = n_reg + 1'b1;
                    if (v_reg == from_reg)
                    begin
                        state_next = astar_pkg::S_POP_RD;
                    end
                    else
                    begin
                        cost_re    = 1'b1;
                        cost_raddr = v_reg;
                        state_next = astar_pkg::S_WALK_WAIT;
                    end
                end
            end
            astar_pkg::S_WALK_WAIT:
            begin
                v_next     = cost_rd_reg.prev;
                state_next = astar_pkg::S_WALK_PUSH;
            end
            astar_pkg::S_POP_RD:
            begin
                stack_re   = 1'b1;
                state_next = astar_pkg::S_POP_OUT;
            end
            astar_pkg::S_POP_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_node_next   = astar_pkg::NODE_BITS'(stack_rd_reg);
                    out_last_next   = (n_reg == N_BITS'(1));
                    out_status_next = astar_pkg::ST_PATH;
                    n_next          = n_reg - 1'b1;
                    if (n_reg == N_BITS'(1))
                    begin
                        state_next = astar_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = astar_pkg::S_POP_RD;
                    end
                end
            end
            astar_pkg::S_SINGLE:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_node_next   = '0;
                    out_last_next   = 1'b1;
                    out_status_next = status_reg;
                    state_next      = astar_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = astar_pkg::S_IDLE;
            end
        endcase
    end

    assign idle       = (state_reg == astar_pkg::S_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_node   = out_node_reg;
    assign out_last   = out_last_reg;
    assign out_status = out_status_reg;

    a_open_closed_apart: assert property (@(posedge clk) disable iff (!rst_n)
        (open_reg & closed_reg) == '0)
        else $error("node both open and closed");

    a_dist_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        dist_done |-> (state_reg == astar_pkg::S_SEL_WAIT
                       || state_reg == astar_pkg::S_EXP_WAIT))
        else $error("distance result with no one waiting");

    a_status_has_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != astar_pkg::ST_PATH) |-> out_last_reg)
        else $error("status result without last");

    a_stack_depth: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= N_BITS'(astar_pkg::MAX_NODES))
        else $error("path stack overrun");

endmodule

/* rtl/astar_graph_path_search_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// astar_graph_path_search_core
// A* shortest path search over a loaded graph of 3D positioned nodes.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                   tuser       tlast
//  s_axis   in   node_id,neighbor_id,pos_x,pos_y,pos_z,  operation   -
//                from_node,to_node
//  m_axis   out  path_node                               status      last
//
//  clear, load and add edge go straight into the graph store and leave the core ready for the next item.
//  a query runs a lowest-f scan over all open nodes, then relaxes the
//  neighbors of the chosen node, until the goal is chosen or none is open;
//  each scanned node costs one pass of the distance unit (squares on one
//  multiplier, 25-step root). the path is then walked back via the cost memory.
//  no item is taken while a query runs; results wait in the output register.
//  reset clears the graph (present mask and row valid bits) at once.
// ----------------------------------------------------------------------------
module astar_graph_path_search_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // node_id, neighbor_id, pos_x, pos_y, pos_z, from_node, to_node
    input  logic [astar_pkg::IN_TDATA_BITS-1:0]    s_axis_tdata,
    // operation
    input  logic [astar_pkg::OP_BITS-1:0]          s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // path_node
    output logic [astar_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata,
    output logic                                   m_axis_tlast,
    // status
    output logic [astar_pkg::STATUS_BITS-1:0]      m_axis_tuser
);

    logic                  accept;
    logic                  idle;
    astar_pkg::op_t        op;
    astar_pkg::graph_wr_t  wr;
    astar_pkg::graph_rd_t  rd;
    astar_pkg::query_t     query;
    astar_pkg::pos_t       pos_rd;
    astar_pkg::mask_t      adj_rd;
    astar_pkg::mask_t      present;
    astar_pkg::node_t      out_node;
    astar_pkg::status_t    out_status;

    assign accept        = s_axis_tvalid && idle;
    assign s_axis_tready = idle;
    assign op            = astar_pkg::op_t'(s_axis_tuser);

    always_comb
    begin
        wr.clear    = 1'b0;
        wr.load     = 1'b0;
        wr.add_edge = 1'b0;
        query.valid = 1'b0;
        wr.node     = s_axis_tdata[astar_pkg::OFS_NODE +: astar_pkg::NODE_BITS];
        wr.nbr      = s_axis_tdata[astar_pkg::OFS_NBR +: astar_pkg::NODE_BITS];
        wr.pos.x    = s_axis_tdata[astar_pkg::OFS_X +: astar_pkg::COORD_BITS];
        wr.pos.y    = s_axis_tdata[astar_pkg::OFS_Y +: astar_pkg::COORD_BITS];
        wr.pos.z    = s_axis_tdata[astar_pkg::OFS_Z +: astar_pkg::COORD_BITS];
        query.from_node = s_axis_tdata[astar_pkg::OFS_FROM +: astar_pkg::NODE_BITS];
        query.to_node   = s_axis_tdata[astar_pkg::OFS_TO +: astar_pkg::NODE_BITS];
        unique case (op)
            astar_pkg::OP_CLEAR: wr.clear    = accept;
            astar_pkg::OP_LOAD:  wr.load     = accept;
            astar_pkg::OP_EDGE:  wr.add_edge = accept;
            astar_pkg::OP_FIND:  query.valid = accept;
            default:             query.valid = 1'b0;
        endcase
    end

    astar_graph u_graph (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd      (rd),
        .pos_rd  (pos_rd),
        .adj_rd  (adj_rd),
        .present (present)
    );

    astar_search u_search (
        .clk        (clk),
        .rst_n      (rst_n),
        .query      (query),
        .idle       (idle),
        .rd         (rd),
        .pos_rd     (pos_rd),
        .adj_rd     (adj_rd),
        .present    (present),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_node   (out_node),
        .out_last   (m_axis_tlast),
        .out_status (out_status)
    );

    assign m_axis_tdata = astar_pkg::OUT_TDATA_BITS'(out_node);
    assign m_axis_tuser = out_status;

endmodule
